// ===== rtl/core/gsks_pkg.sv =====
// Shared types and constants for the gated scalar Kalman smoother.
package gsks_pkg;

   // Datapath commands issued by the controller
   localparam logic [3:0] CMD_NONE  = 4'd0;
   localparam logic [3:0] CMD_LOAD  = 4'd1;
   localparam logic [3:0] CMD_DIV   = 4'd2;
   localparam logic [3:0] CMD_MDD   = 4'd3;
   localparam logic [3:0] CMD_MGG   = 4'd4;
   localparam logic [3:0] CMD_MGGM  = 4'd5;
   localparam logic [3:0] CMD_MS    = 4'd6;
   localparam logic [3:0] CMD_ME    = 4'd7;
   localparam logic [3:0] CMD_MP    = 4'd8;
   localparam logic [3:0] CMD_MY    = 4'd9;
   localparam logic [3:0] CMD_WRITE = 4'd10;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_FILTER_MODE = 3'd0;
   localparam logic [2:0] REG_MEASURE_VAR = 3'd1;
   localparam logic [2:0] REG_GATE_THRESH = 3'd2;
   localparam logic [2:0] REG_PROCESS_NSE = 3'd3;
   localparam logic [2:0] REG_FIXED_MEAS  = 3'd4;

   // Reset values
   localparam logic [15:0] RST_MEASURE_VAR = 16'd100;
   localparam logic [7:0]  RST_GATE_THRESH = 8'd48;
   localparam logic [15:0] RST_PROCESS_NSE = 16'd10;
   localparam logic [15:0] RST_FIXED_MEAS  = 16'd10;
   localparam logic [23:0] RST_VARIANCE    = 24'd25600;
   localparam logic [23:0] RST_COVARIANCE  = 24'd2560;
   localparam logic [23:0] VAR_MAX         = 24'hFFFFFF;

   // Gain divider produces 17 quotient bits
   localparam int DIV_STEPS = 17;

   typedef struct packed {
      logic [3:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

// ===== rtl/core/gated_scalar_kalman_smoother_top.sv =====
// Top level of the gated scalar Kalman smoother.
//
// Usage: one sample item enters on the req_ stream (tuser = channel, tdata =
// sample) and one filtered item leaves on the rsp_ stream (tuser = channel and
// gated flag, tdata = estimate). Each channel keeps its own estimate and
// variances; adaptive or fixed-noise mode is selected through the csr_ port.
// The gain is formed by a restoring divider producing one quotient bit a cycle,
// followed by seven steps on one shared 17x24 multiplier and a write-back step.
// A new item is taken only after the last one is written back; req_tready is
// high only between items. A finished item sits in the output register, so the
// next sample is taken while it waits; a stalled receiver holds back only the
// write-back of the following item. Reset (synchronous, active high) loads the
// register defaults and returns every channel to estimate 0, variances 100.0,
// covariance 10.0. Configuration must be written by the user only while the
// block is idle; the block itself does not enforce this.
module gated_scalar_kalman_smoother_top #(
   parameter int NUM_CHANNELS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic [2:0]  req_tuser,   // [2:0] channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] estimate
   output logic [3:0]  rsp_tuser,   // [2:0] channel_out, [3] gated
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   gsks_pkg::dp_cmd_type    cmd;
   gsks_pkg::dp_status_type status;
   logic [2:0]  out_channel;
   logic [15:0] out_estimate;
   logic        out_gated;

   gsks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gsks_datapath #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_channel   (req_tuser),
      .in_sample    (req_tdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .out_channel  (out_channel),
      .out_estimate (out_estimate),
      .out_gated    (out_gated)
   );

   assign rsp_tdata = out_estimate;
   assign rsp_tuser = {out_gated, out_channel};

endmodule

// ===== rtl/core/gsks_ctrl.sv =====
// Sequencer for the smoother: load, divide, multiply steps, write back.
module gsks_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  gsks_pkg::dp_status_type status,
   output gsks_pkg::dp_cmd_type   cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;
   localparam logic [3:0] ST_DD    = 4'd2;
   localparam logic [3:0] ST_GG    = 4'd3;
   localparam logic [3:0] ST_GGM   = 4'd4;
   localparam logic [3:0] ST_S     = 4'd5;
   localparam logic [3:0] ST_E     = 4'd6;
   localparam logic [3:0] ST_P     = 4'd7;
   localparam logic [3:0] ST_Y     = 4'd8;
   localparam logic [3:0] ST_WRITE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   // Take no item while reset is held
   assign req_tready = (state_ff == ST_IDLE) && !reset;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = gsks_pkg::CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.op   = gsks_pkg::CMD_LOAD;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = gsks_pkg::CMD_DIV;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(gsks_pkg::DIV_STEPS - 1)) state_in = ST_DD;
         end
         ST_DD: begin
            cmd.op = gsks_pkg::CMD_MDD;  state_in = ST_GG;
         end
         ST_GG: begin
            cmd.op = gsks_pkg::CMD_MGG;  state_in = ST_GGM;
         end
         ST_GGM: begin
            cmd.op = gsks_pkg::CMD_MGGM; state_in = ST_S;
         end
         ST_S: begin
            cmd.op = gsks_pkg::CMD_MS;   state_in = ST_E;
         end
         ST_E: begin
            cmd.op = gsks_pkg::CMD_ME;   state_in = ST_P;
         end
         ST_P: begin
            cmd.op = gsks_pkg::CMD_MP;   state_in = ST_Y;
         end
         ST_Y: begin
            cmd.op = gsks_pkg::CMD_MY;   state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.op   = gsks_pkg::CMD_WRITE;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/gsks_datapath.sv =====
// Datapath: channel state, config registers, gain divider, shared multiplier, output.
module gsks_datapath #(
   parameter int NUM_CHANNELS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic [2:0]             in_channel,
   input  logic [15:0]            in_sample,
   input  gsks_pkg::dp_cmd_type   cmd,
   output gsks_pkg::dp_status_type status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [2:0]             out_channel,
   output logic [15:0]            out_estimate,
   output logic                   out_gated
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Configuration registers
   logic        mode_ff;
   logic [15:0] mvar_ff, qnse_ff, rnse_ff;
   logic [7:0]  gate_ff;

   // Per-channel state
   logic [15:0] est_ff [NUM_CHANNELS];
   logic [23:0] evar_ff [NUM_CHANNELS];
   logic [23:0] svar_ff [NUM_CHANNELS];
   logic [23:0] pcov_ff [NUM_CHANNELS];

   // Item working registers
   logic [2:0]       ch_ff;
   logic             inrange_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [15:0]      y_ff, d_ff;
   logic             xge_ff, pos_ff;
   logic [23:0]      p_ff;
   logic [25:0]      den_ff;
   logic [26:0]      rem_ff;
   logic [16:0]      q_ff;
   logic [15:0]      k_ff;
   logic [39:0]      lhs_ff;
   logic             gated_ff;
   logic [23:0]      s_ff, e_ff, pnew_ff;
   logic [40:0]      prod_ff;

   // Output register
   logic        ovalid_ff;
   logic [2:0]  och_ff;
   logic [15:0] oest_ff;
   logic        ogated_ff;

   logic [23:0]      m8;
   logic [IDX_W-1:0] idx_in;
   logic             inrange_in;
   logic [15:0]      y_in;
   logic [24:0]      es, psum;
   logic [23:0]      psat;
   logic [16:0]      mul_a;
   logic [23:0]      mul_b;
   logic [40:0]      mul_p;
   logic [26:0]      rem_sub;
   logic             rem_ge;
   logic [16:0]      kc;
   logic [24:0]      esum;
   logic [32:0]      rnd;
   logic [15:0]      y_new;

   assign m8         = {mvar_ff, 8'd0};
   assign idx_in     = IDX_W'(in_channel);
   assign inrange_in = (32'(in_channel) < NUM_CHANNELS);
   assign y_in       = inrange_in ? est_ff[idx_in] : 16'd0;
   assign es         = {1'b0, evar_ff[idx_in]} + {1'b0, svar_ff[idx_in]};
   assign psum       = {1'b0, pcov_ff[idx_in]} + {1'b0, qnse_ff, 8'd0};
   assign psat       = psum[24] ? gsks_pkg::VAR_MAX : psum[23:0];
   assign kc         = 17'h10000 - {1'b0, k_ff};

   // Restoring divider step
   assign rem_ge  = (rem_ff >= {1'b0, den_ff});
   assign rem_sub = rem_ff - (rem_ge ? {1'b0, den_ff} : 27'd0);

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         gsks_pkg::CMD_MDD:  begin mul_a = {1'b0, d_ff};            mul_b = {8'd0, d_ff}; end
         gsks_pkg::CMD_MGG:  begin mul_a = {9'd0, gate_ff};         mul_b = {16'd0, gate_ff}; end
         gsks_pkg::CMD_MGGM: begin mul_a = {1'b0, prod_ff[15:0]};   mul_b = {8'd0, mvar_ff}; end
         gsks_pkg::CMD_MS:   begin mul_a = {1'b0, k_ff};            mul_b = m8; end
         gsks_pkg::CMD_ME:   begin mul_a = kc;                      mul_b = m8; end
         gsks_pkg::CMD_MP:   begin mul_a = kc;                      mul_b = p_ff; end
         gsks_pkg::CMD_MY:   begin mul_a = {1'b0, k_ff};            mul_b = {8'd0, d_ff}; end
         default: ;
      endcase
   end
   assign mul_p = {24'd0, mul_a} * {17'd0, mul_b};

   // Write-back values
   assign esum  = {1'b0, prod_ff[39:16]} + {1'b0, s_ff};
   assign rnd   = {1'b0, prod_ff[31:0]} + 33'd65535;
   assign y_new = xge_ff ? (y_ff + prod_ff[31:16]) : (y_ff - rnd[31:16]);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         mvar_ff <= gsks_pkg::RST_MEASURE_VAR;
         gate_ff <= gsks_pkg::RST_GATE_THRESH;
         qnse_ff <= gsks_pkg::RST_PROCESS_NSE;
         rnse_ff <= gsks_pkg::RST_FIXED_MEAS;
      end else if (csr_we) begin
         unique case (csr_index)
            gsks_pkg::REG_FILTER_MODE: mode_ff <= csr_wdata[0];
            gsks_pkg::REG_MEASURE_VAR: mvar_ff <= csr_wdata;
            gsks_pkg::REG_GATE_THRESH: gate_ff <= csr_wdata[7:0];
            gsks_pkg::REG_PROCESS_NSE: qnse_ff <= csr_wdata;
            gsks_pkg::REG_FIXED_MEAS:  rnse_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Item working registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         gsks_pkg::CMD_LOAD: begin
            ch_ff      <= in_channel;
            inrange_ff <= inrange_in;
            idx_ff     <= idx_in;
            y_ff       <= y_in;
            xge_ff     <= (in_sample >= y_in);
            pos_ff     <= (in_sample > y_in);
            d_ff       <= (in_sample >= y_in) ? (in_sample - y_in) : (y_in - in_sample);
            p_ff       <= psat;
            q_ff       <= '0;
            if (mode_ff) begin
               rem_ff <= {3'd0, psat};
               den_ff <= {2'd0, psat} + {2'd0, rnse_ff, 8'd0};
            end else begin
               rem_ff <= {2'd0, es};
               den_ff <= {1'b0, es} + {2'd0, m8};
            end
         end
         gsks_pkg::CMD_DIV: begin
            q_ff   <= {q_ff[15:0], rem_ge};
            rem_ff <= {rem_sub[25:0], 1'b0};
         end
         gsks_pkg::CMD_MDD: begin
            k_ff    <= (den_ff == '0) ? 16'd0 : (q_ff[16] ? 16'hFFFF : q_ff[15:0]);
            prod_ff <= mul_p;
         end
         gsks_pkg::CMD_MGG: begin
            lhs_ff  <= {prod_ff[31:0], 8'd0};
            prod_ff <= mul_p;
         end
         gsks_pkg::CMD_MGGM: prod_ff <= mul_p;
         gsks_pkg::CMD_MS: begin
            gated_ff <= !mode_ff && pos_ff && (lhs_ff > {8'd0, prod_ff[31:0]});
            prod_ff  <= mul_p;
         end
         gsks_pkg::CMD_ME: begin
            s_ff    <= prod_ff[39:16];
            prod_ff <= mul_p;
         end
         gsks_pkg::CMD_MP: begin
            e_ff    <= esum[24] ? gsks_pkg::VAR_MAX : esum[23:0];
            prod_ff <= mul_p;
         end
         gsks_pkg::CMD_MY: begin
            pnew_ff <= prod_ff[39:16];
            prod_ff <= mul_p;
         end
         default: ;
      endcase
   end

   // Channel state: reset and write back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            est_ff[i]  <= '0;
            evar_ff[i] <= gsks_pkg::RST_VARIANCE;
            svar_ff[i] <= gsks_pkg::RST_VARIANCE;
            pcov_ff[i] <= gsks_pkg::RST_COVARIANCE;
         end
      end else if (cmd.op == gsks_pkg::CMD_WRITE && inrange_ff) begin
         est_ff[idx_ff] <= y_new;
         if (mode_ff) begin
            pcov_ff[idx_ff] <= pnew_ff;
         end else if (gated_ff) begin
            evar_ff[idx_ff] <= m8;
            svar_ff[idx_ff] <= m8;
         end else begin
            evar_ff[idx_ff] <= e_ff;
            svar_ff[idx_ff] <= s_ff;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.op == gsks_pkg::CMD_WRITE) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == gsks_pkg::CMD_WRITE) begin
         och_ff    <= ch_ff;
         oest_ff   <= inrange_ff ? y_new : 16'd0;
         ogated_ff <= inrange_ff && gated_ff;
      end
   end

   assign status.out_busy = ovalid_ff && !rsp_tready;
   assign rsp_tvalid      = ovalid_ff;
   assign out_channel     = och_ff;
   assign out_estimate    = oest_ff;
   assign out_gated       = ogated_ff;

endmodule
